// ===== hw/rtl/jslp_pkg.sv =====
// Shared types, constants and coefficient tables of the joint stereo line processor.
`default_nettype none

package jslp_pkg;

    localparam int SAMPLE_W            = 32;
    localparam int POS_W               = 5;
    localparam int CFG_IDX_W           = 3;
    localparam int COEF_SRC_FRAC       = 28;
    localparam int COEF_SRC_W          = 29;
    localparam int COEF_FRAC_BITS_DEF  = 14;
    localparam int SAMPLE_BITS_DEF     = 32;
    localparam int MS_SCALE            = 181;
    localparam int MS_SHIFT            = 8;
    localparam int MS_SUM_W            = 33;
    localparam int MS_PROD_W           = 41;
    localparam int TAN_LAST            = 6;
    localparam int LSF_IDX_W           = 4;
    localparam int LSF_LAST_IDX        = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MONO      = 3'd0,
        CFG_IS_EN     = 3'd1,
        CFG_MS_EN     = 3'd2,
        CFG_MPEG1     = 3'd3,
        CFG_LSF_SEL   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        R_ORIG = 2'd0,
        R_LEFT = 2'd1,
        R_PROD = 2'd2
    } t_rsel;

    typedef struct packed {
        logic mono;
        logic is_en;
        logic ms_en;
        logic mpeg1;
        logic lsf_sel;
    } t_cfg;

    typedef struct packed {
        logic  l_prod;
        t_rsel r_sel;
        logic  ms_act;
    } t_is_ctrl;

    function automatic logic [COEF_SRC_W-1:0] tan_coef(input logic [2:0] idx);
        logic [COEF_SRC_W-1:0] c;
        unique case (idx)
            3'd0:    c = 29'h0000_0000;
            3'd1:    c = 29'h0361_962f;
            3'd2:    c = 29'h05db_3d74;
            3'd3:    c = 29'h0800_0000;
            3'd4:    c = 29'h0a24_c28c;
            3'd5:    c = 29'h0c9e_69d1;
            3'd6:    c = 29'h1000_0000;
            default: c = 29'h0000_0000;
        endcase
        return c;
    endfunction

    function automatic logic [COEF_SRC_W-1:0] lsf_coef(input logic sel,
                                                       input logic [LSF_IDX_W-1:0] idx);
        logic [COEF_SRC_W-1:0] c;
        if (!sel) begin
            unique case (idx)
                4'd0:    c = 29'h0d74_4fcd;
                4'd1:    c = 29'h0b50_4f33;
                4'd2:    c = 29'h0983_7f05;
                4'd3:    c = 29'h0800_0000;
                4'd4:    c = 29'h06ba_27e6;
                4'd5:    c = 29'h05a8_279a;
                4'd6:    c = 29'h04c1_bf83;
                4'd7:    c = 29'h0400_0000;
                4'd8:    c = 29'h035d_13f3;
                4'd9:    c = 29'h02d4_13cd;
                4'd10:   c = 29'h0260_dfc1;
                4'd11:   c = 29'h0200_0000;
                4'd12:   c = 29'h01ae_89fa;
                4'd13:   c = 29'h016a_09e6;
                default: c = 29'h0130_6fe1;
            endcase
        end else begin
            unique case (idx)
                4'd0:    c = 29'h0b50_4f33;
                4'd1:    c = 29'h0800_0000;
                4'd2:    c = 29'h05a8_279a;
                4'd3:    c = 29'h0400_0000;
                4'd4:    c = 29'h02d4_13cd;
                4'd5:    c = 29'h0200_0000;
                4'd6:    c = 29'h016a_09e6;
                4'd7:    c = 29'h0100_0000;
                4'd8:    c = 29'h00b5_04f3;
                4'd9:    c = 29'h0080_0000;
                4'd10:   c = 29'h005a_827a;
                4'd11:   c = 29'h0040_0000;
                4'd12:   c = 29'h002d_413d;
                4'd13:   c = 29'h0020_0000;
                default: c = 29'h0016_a09e;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jslp_line_if.sv =====
// Input channel carrying one left/right line pair with its band flags.
`default_nettype none

interface jslp_line_if;
    logic                                valid;
    logic                                ready;
    logic signed [jslp_pkg::SAMPLE_W-1:0] left_line;
    logic signed [jslp_pkg::SAMPLE_W-1:0] right_line;
    logic [jslp_pkg::POS_W-1:0]           band_position;
    logic                                in_intensity_region;
    logic                                position_legal;
    logic                                in_ms_range;
    logic                                last_line;

    modport source (
        output valid, left_line, right_line, band_position, in_intensity_region,
               position_legal, in_ms_range, last_line,
        input  ready
    );

    modport sink (
        input  valid, left_line, right_line, band_position, in_intensity_region,
               position_legal, in_ms_range, last_line,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/jslp_res_if.sv =====
// Output channel carrying one decoded left/right line pair.
`default_nettype none

interface jslp_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [jslp_pkg::SAMPLE_W-1:0] left_out;
    logic signed [jslp_pkg::SAMPLE_W-1:0] right_out;
    logic                                last_out;

    modport source (
        output valid, left_out, right_out, last_out,
        input  ready
    );

    modport sink (
        input  valid, left_out, right_out, last_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/jslp_sat.sv =====
// Saturate a wide signed value to the sample range and sign-extend to the field width.
`default_nettype none

module jslp_sat #(
    parameter int IN_W        = 33,
    parameter int SAMPLE_BITS = jslp_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [IN_W-1:0]               i_val,
    output logic signed [jslp_pkg::SAMPLE_W-1:0] o_val
);
    localparam logic signed [jslp_pkg::SAMPLE_W:0] HI_X =
        (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    localparam logic signed [jslp_pkg::SAMPLE_W:0] LO_X = -HI_X - 33'sd1;

    logic [IN_W-SAMPLE_BITS:0] top_bits;

    always_comb begin
        top_bits = i_val[IN_W-1:SAMPLE_BITS-1];
        if ((&top_bits) || !(|top_bits)) begin
            o_val = jslp_pkg::SAMPLE_W'($signed(i_val[SAMPLE_BITS-1:0]));
        end else if (i_val[IN_W-1]) begin
            o_val = LO_X[jslp_pkg::SAMPLE_W-1:0];
        end else begin
            o_val = HI_X[jslp_pkg::SAMPLE_W-1:0];
        end
    end
endmodule

`default_nettype wire

// ===== hw/rtl/jslp_decode.sv =====
// Intensity and mid/side decode: coefficient lookup and output selection per line.
`default_nettype none

module jslp_decode #(
    parameter int COEF_FRAC_BITS = jslp_pkg::COEF_FRAC_BITS_DEF
) (
    input  jslp_pkg::t_cfg                  i_cfg,
    input  logic [jslp_pkg::POS_W-1:0]      i_pos,
    input  logic                            i_region,
    input  logic                            i_legal,
    input  logic                            i_ms_range,
    output jslp_pkg::t_is_ctrl              o_ctrl,
    output logic [COEF_FRAC_BITS:0]         o_coef_l,
    output logic [COEF_FRAC_BITS:0]         o_coef_r
);
    localparam int COEF_W = COEF_FRAC_BITS + 1;
    localparam int C_SH   = jslp_pkg::COEF_SRC_FRAC - COEF_FRAC_BITS;

    logic                                   pos_low;
    logic                                   is_act;
    logic [2:0]                             tan_idx;
    logic [jslp_pkg::POS_W-1:0]             lsf_raw;
    logic [jslp_pkg::LSF_IDX_W-1:0]         lsf_idx;
    logic [jslp_pkg::COEF_SRC_W-1:0]        src_l;
    logic [jslp_pkg::COEF_SRC_W-1:0]        src_r;
    logic [jslp_pkg::COEF_SRC_W-1:0]        sh_l;
    logic [jslp_pkg::COEF_SRC_W-1:0]        sh_r;

    always_comb begin
        pos_low = (i_pos <= jslp_pkg::POS_W'(jslp_pkg::TAN_LAST));
        is_act  = !i_cfg.mono && i_cfg.is_en && i_region &&
                  (i_cfg.mpeg1 ? pos_low : i_legal);
        tan_idx = i_pos[2:0];
        lsf_raw = (i_pos - 5'd1) >> 1;
        lsf_idx = lsf_raw[jslp_pkg::LSF_IDX_W-1:0];
        if (lsf_idx > jslp_pkg::LSF_IDX_W'(jslp_pkg::LSF_LAST_IDX)) begin
            lsf_idx = jslp_pkg::LSF_IDX_W'(jslp_pkg::LSF_LAST_IDX);
        end

        if (i_cfg.mpeg1) begin
            src_l = jslp_pkg::tan_coef(tan_idx);
            src_r = jslp_pkg::tan_coef(3'(jslp_pkg::TAN_LAST) - tan_idx);
        end else begin
            src_l = jslp_pkg::lsf_coef(i_cfg.lsf_sel, lsf_idx);
            src_r = src_l;
        end
        sh_l     = src_l >> C_SH;
        sh_r     = src_r >> C_SH;
        o_coef_l = sh_l[COEF_W-1:0];
        o_coef_r = sh_r[COEF_W-1:0];

        o_ctrl.ms_act = !i_cfg.mono && i_cfg.ms_en && i_ms_range;
        priority if (!is_act) begin
            o_ctrl.l_prod = 1'b0;
            o_ctrl.r_sel  = jslp_pkg::R_ORIG;
        end else if (i_cfg.mpeg1) begin
            o_ctrl.l_prod = 1'b1;
            o_ctrl.r_sel  = jslp_pkg::R_PROD;
        end else if (i_pos == '0) begin
            o_ctrl.l_prod = 1'b0;
            o_ctrl.r_sel  = jslp_pkg::R_LEFT;
        end else if (i_pos[0]) begin
            o_ctrl.l_prod = 1'b1;
            o_ctrl.r_sel  = jslp_pkg::R_LEFT;
        end else begin
            o_ctrl.l_prod = 1'b0;
            o_ctrl.r_sel  = jslp_pkg::R_PROD;
        end
    end
endmodule

`default_nettype wire

// ===== hw/rtl/joint_stereo_line_processor_core.sv =====
// Joint stereo line processor: intensity stereo then mid/side on one line pair per cycle unless the output stalls.
// Throughput: one transaction per cycle; five register stages (decode, coefficient
// multiply, scale and select, mid/side multiply, shift and saturate) each hold while full
// and blocked, so a bubble anywhere is filled and a stall loses nothing.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
`default_nettype none

module joint_stereo_line_processor_core #(
    parameter int COEF_FRAC_BITS = jslp_pkg::COEF_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS    = jslp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jslp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic                             i_cfg_wdata,
    jslp_line_if.sink                        i_line,
    jslp_res_if.source                       o_res
);
    localparam int SW     = jslp_pkg::SAMPLE_W;
    localparam int COEF_W = COEF_FRAC_BITS + 1;
    localparam int PW     = SW + COEF_W + 1;
    localparam int PSH_W  = PW - COEF_FRAC_BITS;
    localparam int SUM_W  = jslp_pkg::MS_SUM_W;
    localparam int MSP_W  = jslp_pkg::MS_PROD_W;
    localparam int MSS_W  = MSP_W - jslp_pkg::MS_SHIFT;

    jslp_pkg::t_cfg r_cfg;

    logic en1, en2, en3, en4, en5;

    jslp_pkg::t_is_ctrl     dec_ctrl;
    logic [COEF_W-1:0]      dec_cl;
    logic [COEF_W-1:0]      dec_cr;

    logic                   r1_vld;
    logic signed [SW-1:0]   r1_l, r1_r;
    logic [COEF_W-1:0]      r1_cl, r1_cr;
    jslp_pkg::t_is_ctrl     r1_ctrl;
    logic                   r1_last;

    logic                   r2_vld;
    logic signed [PW-1:0]   r2_pl, r2_pr;
    logic signed [PW-1:0]   n2_pl, n2_pr;
    logic signed [SW-1:0]   r2_l, r2_r;
    jslp_pkg::t_is_ctrl     r2_ctrl;
    logic                   r2_last;

    logic signed [SW-1:0]   sat_pl, sat_pr;
    logic signed [SW-1:0]   n3_l, n3_r;
    logic                   r3_vld;
    logic signed [SW-1:0]   r3_l, r3_r;
    logic                   r3_ms;
    logic                   r3_last;

    logic signed [SUM_W-1:0] ms_sum, ms_dif;
    logic signed [MSP_W-1:0] n4_a, n4_d;
    logic                    r4_vld;
    logic signed [MSP_W-1:0] r4_a, r4_d;
    logic signed [SW-1:0]    r4_l, r4_r;
    logic                    r4_ms;
    logic                    r4_last;

    logic signed [SW-1:0]   sat_a, sat_d;
    logic                   r5_vld;
    logic signed [SW-1:0]   r5_l, r5_r;
    logic                   r5_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mono: 1'b0, is_en: 1'b0, ms_en: 1'b0, mpeg1: 1'b1, lsf_sel: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jslp_pkg::CFG_MONO:    r_cfg.mono    <= i_cfg_wdata;
                jslp_pkg::CFG_IS_EN:   r_cfg.is_en   <= i_cfg_wdata;
                jslp_pkg::CFG_MS_EN:   r_cfg.ms_en   <= i_cfg_wdata;
                jslp_pkg::CFG_MPEG1:   r_cfg.mpeg1   <= i_cfg_wdata;
                jslp_pkg::CFG_LSF_SEL: r_cfg.lsf_sel <= i_cfg_wdata;
                default:               r_cfg         <= r_cfg;
            endcase
        end
    end

    assign en5 = !r5_vld || o_res.ready;
    assign en4 = !r4_vld || en5;
    assign en3 = !r3_vld || en4;
    assign en2 = !r2_vld || en3;
    assign en1 = !r1_vld || en2;
    assign i_line.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            if (en1) r1_vld <= i_line.valid;
            if (en2) r2_vld <= r1_vld;
            if (en3) r3_vld <= r2_vld;
            if (en4) r4_vld <= r3_vld;
            if (en5) r5_vld <= r4_vld;
        end
    end

    jslp_decode #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_decode (
        .i_cfg      (r_cfg),
        .i_pos      (i_line.band_position),
        .i_region   (i_line.in_intensity_region),
        .i_legal    (i_line.position_legal),
        .i_ms_range (i_line.in_ms_range),
        .o_ctrl     (dec_ctrl),
        .o_coef_l   (dec_cl),
        .o_coef_r   (dec_cr)
    );

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_l    <= i_line.left_line;
            r1_r    <= i_line.right_line;
            r1_cl   <= dec_cl;
            r1_cr   <= dec_cr;
            r1_ctrl <= dec_ctrl;
            r1_last <= i_line.last_line;
        end
    end

    assign n2_pl = PW'(r1_l) * PW'($signed({1'b0, r1_cl}));
    assign n2_pr = PW'(r1_l) * PW'($signed({1'b0, r1_cr}));

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_pl   <= n2_pl;
            r2_pr   <= n2_pr;
            r2_l    <= r1_l;
            r2_r    <= r1_r;
            r2_ctrl <= r1_ctrl;
            r2_last <= r1_last;
        end
    end

    jslp_sat #(.IN_W(PSH_W), .SAMPLE_BITS(SAMPLE_BITS)) u_sat_pl (
        .i_val (r2_pl[PW-1:COEF_FRAC_BITS]),
        .o_val (sat_pl)
    );

    jslp_sat #(.IN_W(PSH_W), .SAMPLE_BITS(SAMPLE_BITS)) u_sat_pr (
        .i_val (r2_pr[PW-1:COEF_FRAC_BITS]),
        .o_val (sat_pr)
    );

    always_comb begin
        n3_l = r2_ctrl.l_prod ? sat_pl : r2_l;
        unique case (r2_ctrl.r_sel)
            jslp_pkg::R_ORIG: n3_r = r2_r;
            jslp_pkg::R_LEFT: n3_r = r2_l;
            jslp_pkg::R_PROD: n3_r = sat_pr;
            default:          n3_r = r2_r;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_l    <= n3_l;
            r3_r    <= n3_r;
            r3_ms   <= r2_ctrl.ms_act;
            r3_last <= r2_last;
        end
    end

    assign ms_sum = SUM_W'(r3_l) + SUM_W'(r3_r);
    assign ms_dif = SUM_W'(r3_l) - SUM_W'(r3_r);
    assign n4_a   = MSP_W'(ms_sum) * $signed(MSP_W'(jslp_pkg::MS_SCALE));
    assign n4_d   = MSP_W'(ms_dif) * $signed(MSP_W'(jslp_pkg::MS_SCALE));

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_a    <= n4_a;
            r4_d    <= n4_d;
            r4_l    <= r3_l;
            r4_r    <= r3_r;
            r4_ms   <= r3_ms;
            r4_last <= r3_last;
        end
    end

    jslp_sat #(.IN_W(MSS_W), .SAMPLE_BITS(SAMPLE_BITS)) u_sat_a (
        .i_val (r4_a[MSP_W-1:jslp_pkg::MS_SHIFT]),
        .o_val (sat_a)
    );

    jslp_sat #(.IN_W(MSS_W), .SAMPLE_BITS(SAMPLE_BITS)) u_sat_d (
        .i_val (r4_d[MSP_W-1:jslp_pkg::MS_SHIFT]),
        .o_val (sat_d)
    );

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_l    <= r4_ms ? sat_a : r4_l;
            r5_r    <= r4_ms ? sat_d : r4_r;
            r5_last <= r4_last;
        end
    end

    assign o_res.valid     = r5_vld;
    assign o_res.left_out  = r5_l;
    assign o_res.right_out = r5_r;
    assign o_res.last_out  = r5_last;
endmodule

`default_nettype wire

// ===== hw/rtl/jslp_checker.sv =====
// Port-level checks of the joint stereo line processor, bound to the top level.
`default_nettype none

module jslp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  logic i_out_valid,
    input  logic i_out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transaction completed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output stage empty");

    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while output not blocked");
endmodule

bind joint_stereo_line_processor_core jslp_checker u_jslp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_line.valid),
    .i_in_ready  (i_line.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);

`default_nettype wire
